// File: design/pse_pkg.sv
package pse_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int OP_W        = 3;
  localparam int BIT_W       = $clog2(DATA_W);

  localparam logic [OP_W-1:0] OP_PUSH   = OP_W'(0);
  localparam logic [OP_W-1:0] OP_ADD    = OP_W'(1);
  localparam logic [OP_W-1:0] OP_SUB    = OP_W'(2);
  localparam logic [OP_W-1:0] OP_MUL    = OP_W'(3);
  localparam logic [OP_W-1:0] OP_DIV    = OP_W'(4);
  localparam logic [OP_W-1:0] OP_FINISH = OP_W'(5);

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_DIVZERO   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MUL = 2'd2,
    ALU_DIV = 2'd3
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_cmd_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] result;
  } alu_rsp_t;

endpackage

// File: design/pse_if.sv
interface pse_req_if import pse_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic signed [DATA_W-1:0] number;

  modport source (output valid, operation, number, input ready);
  modport sink (input valid, operation, number, output ready);
endinterface

interface pse_rsp_if import pse_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] answer;
  logic [1:0]               status;
  logic                     is_final;

  modport source (output valid, answer, status, is_final, input ready);
  modport sink (input valid, answer, status, is_final, output ready);
endinterface

// File: design/pse_ram.sv
module pse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/pse_alu.sv
module pse_alu import pse_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  alu_cmd_t          cmd,
  input  logic [DATA_W-1:0] left,
  input  logic [DATA_W-1:0] right,
  output alu_rsp_t          rsp
);

  localparam int MSB = DATA_W - 1;

  typedef enum logic [3:0] {
    A_IDLE = 4'b0001,
    A_RUN  = 4'b0010,
    A_FIX  = 4'b0100,
    A_DONE = 4'b1000
  } alu_state_t;

  alu_state_t        state, state_next;
  alu_op_t           op_q;
  logic [BIT_W-1:0]  cnt;
  logic [DATA_W-1:0] acc;
  logic [DATA_W-1:0] sreg;
  logic [DATA_W-1:0] breg;
  logic              carry;
  logic              negq;

  logic [DATA_W-1:0] left_abs;
  logic [DATA_W-1:0] right_abs;
  logic              sum_bit;
  logic              carry_next;
  logic [DATA_W:0]   prod;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W+1:0] diff;
  logic              ge;

  assign left_abs   = left[MSB] ? (~left + DATA_W'(1)) : left;
  assign right_abs  = right[MSB] ? (~right + DATA_W'(1)) : right;
  assign sum_bit    = sreg[0] ^ breg[0] ^ carry;
  assign carry_next = (sreg[0] & breg[0]) | (carry & (sreg[0] ^ breg[0]));
  assign prod       = {1'b0, acc} + (sreg[0] ? {1'b0, breg} : '0);
  assign rem_sh     = {acc, sreg[MSB]};
  assign diff       = {1'b0, rem_sh} - {2'b00, breg};
  assign ge         = ~diff[DATA_W+1];

  assign rsp.done   = (state == A_DONE);
  assign rsp.result = sreg;

  always_comb begin
    state_next = state;
    unique case (state)
      A_IDLE: if (cmd.start) state_next = A_RUN;
      A_RUN:  if (cnt == BIT_W'(DATA_W - 1)) state_next = A_FIX;
      A_FIX:  state_next = A_DONE;
      A_DONE: state_next = A_IDLE;
      default: state_next = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      A_IDLE: begin
        if (cmd.start) begin
          op_q  <= cmd.op;
          cnt   <= '0;
          acc   <= '0;
          carry <= (cmd.op == ALU_SUB);
          negq  <= left[MSB] ^ right[MSB];
          sreg  <= (cmd.op == ALU_DIV) ? left_abs : left;
          case (cmd.op)
            ALU_SUB: breg <= ~right;
            ALU_DIV: breg <= right_abs;
            default: breg <= right;
          endcase
        end
      end
      A_RUN: begin
        cnt <= cnt + BIT_W'(1);
        case (op_q) inside
          ALU_ADD, ALU_SUB: begin
            sreg  <= {sum_bit, sreg[MSB:1]};
            breg  <= {1'b0, breg[MSB:1]};
            carry <= carry_next;
          end
          ALU_MUL: begin
            acc  <= prod[DATA_W:1];
            sreg <= {prod[0], sreg[MSB:1]};
          end
          default: begin
            acc  <= ge ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
            sreg <= {sreg[MSB-1:0], ge};
          end
        endcase
      end
      A_FIX: begin
        if (op_q == ALU_DIV && negq) begin
          sreg <= ~sreg + DATA_W'(1);
        end
      end
      default: ;
    endcase
  end

endmodule

// File: design/postfix_stack_evaluator.sv
// Channel  Dir  Fields                        Meaning
// req      in   operation[2:0], number[31:0]  one token per request
// rsp      out  answer[31:0], status[1:0],    one result per token
//               is_final
//
// Push, finish, errors and unknown codes: S_EXEC, then the output register
// once rsp is free; next request taken in the same cycle the result appears.
// Add, subtract, multiply, divide: S_EXEC, S_CALC on the bit-serial ALU
// (one bit per cycle over 32 bits, plus load and sign fix), then S_WRITE.
// Reset (rst, synchronous) empties the stack; the stack RAM is not cleared.
// A stalled rsp holds its result; a new request is still taken meanwhile.
module postfix_stack_evaluator import pse_pkg::*; (
  input logic  clk,
  input logic  rst,
  pse_req_if.sink   req,
  pse_rsp_if.source rsp
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_CALC  = 4'b0100,
    S_WRITE = 4'b1000
  } state_t;

  state_t             state, state_next;
  logic [COUNT_W-1:0] count, count_next;
  logic [COUNT_W-1:0] count_m1, count_m2;
  logic [DATA_W-1:0]  top, top_next;
  logic [OP_W-1:0]    op_q;
  logic [DATA_W-1:0]  num_q;

  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [DATA_W-1:0]  wr_data;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [DATA_W-1:0]  rd_data;

  alu_cmd_t           alu_cmd;
  alu_rsp_t           alu_rsp;

  logic               accept;
  logic               out_free;
  logic               load_out;
  logic [DATA_W-1:0]  res_answer;
  status_t            res_status;
  logic               res_final;

  logic               out_valid;
  logic [DATA_W-1:0]  out_answer;
  status_t            out_status;
  logic               out_final;

  assign req.ready    = (state == S_IDLE);
  assign accept       = req.valid && req.ready;
  assign out_free     = !out_valid || rsp.ready;
  assign count_m1     = count - COUNT_W'(1);
  assign count_m2     = count - COUNT_W'(2);

  // stack below top lives in RAM; read the entry under top on every request
  assign rd_en        = accept;
  assign rd_addr      = count_m2[ADDR_W-1:0];

  assign rsp.valid    = out_valid;
  assign rsp.answer   = out_answer;
  assign rsp.status   = out_status;
  assign rsp.is_final = out_final;

  pse_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pse_alu u_alu (
    .clk   (clk),
    .rst   (rst),
    .cmd   (alu_cmd),
    .left  (rd_data),
    .right (top),
    .rsp   (alu_rsp)
  );

  always_comb begin
    state_next    = state;
    count_next    = count;
    top_next      = top;
    wr_en         = 1'b0;
    wr_addr       = count_m1[ADDR_W-1:0];
    wr_data       = top;
    alu_cmd.start = 1'b0;
    load_out      = 1'b0;
    res_answer    = '0;
    res_status    = ST_OK;
    res_final     = 1'b0;

    case (op_q)
      OP_SUB:  alu_cmd.op = ALU_SUB;
      OP_MUL:  alu_cmd.op = ALU_MUL;
      OP_DIV:  alu_cmd.op = ALU_DIV;
      default: alu_cmd.op = ALU_ADD;
    endcase

    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_EXEC;
      end
      S_EXEC: begin
        case (op_q) inside
          OP_PUSH: begin
            if (out_free) begin
              load_out   = 1'b1;
              state_next = S_IDLE;
              if (count == COUNT_W'(STACK_DEPTH)) begin
                res_status = ST_OVERFLOW;
              end else begin
                wr_en      = (count != '0);
                top_next   = num_q;
                count_next = count + COUNT_W'(1);
                res_answer = num_q;
              end
            end
          end
          OP_FINISH: begin
            if (out_free) begin
              load_out   = 1'b1;
              state_next = S_IDLE;
              res_final  = 1'b1;
              if (count == '0) begin
                res_status = ST_UNDERFLOW;
              end else begin
                res_answer = top;
                top_next   = rd_data;
                count_next = count_m1;
              end
            end
          end
          OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
            if (count < COUNT_W'(2)) begin
              if (out_free) begin
                load_out   = 1'b1;
                state_next = S_IDLE;
                res_status = ST_UNDERFLOW;
              end
            end else if (op_q == OP_DIV && top == '0) begin
              if (out_free) begin
                load_out   = 1'b1;
                state_next = S_IDLE;
                res_status = ST_DIVZERO;
              end
            end else begin
              alu_cmd.start = 1'b1;
              state_next    = S_CALC;
            end
          end
          default: begin
            if (out_free) begin
              load_out   = 1'b1;
              state_next = S_IDLE;
            end
          end
        endcase
      end
      S_CALC: begin
        if (alu_rsp.done) state_next = S_WRITE;
      end
      S_WRITE: begin
        if (out_free) begin
          load_out   = 1'b1;
          res_answer = alu_rsp.result;
          top_next   = alu_rsp.result;
          count_next = count_m1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    top <= top_next;
    if (accept) begin
      op_q  <= req.operation;
      num_q <= req.number;
    end
    if (load_out) begin
      out_answer <= res_answer;
      out_status <= res_status;
      out_final  <= res_final;
    end
  end

endmodule

// File: design/pse_checker.sv
module pse_checker import pse_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic [DATA_W-1:0] answer,
  input logic [1:0]        status,
  input logic              is_final
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=>
      rsp_valid && $stable(answer) && $stable(status) && $stable(is_final))
    else $error("rsp changed while stalled");

  a_one_token: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while a token is in work");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ST_OK |-> answer == '0)
    else $error("error result with nonzero answer");

  a_err_final: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_OVERFLOW || status == ST_DIVZERO) |-> !is_final)
    else $error("overflow or divide by zero flagged as final");

endmodule

bind postfix_stack_evaluator pse_checker u_pse_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .answer    (rsp.answer),
  .status    (rsp.status),
  .is_final  (rsp.is_final)
);
